// ----- rtl/nec_ir_pulse_distance_decoder_top_defines.svh -----
// Assertion macros for the NEC IR pulse-distance decoder.
`ifndef NEC_IR_PULSE_DISTANCE_DECODER_TOP_DEFINES_SVH
`define NEC_IR_PULSE_DISTANCE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define NEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define NEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nec_ir_pkg.sv -----
// Shared types, codes and constants of the NEC IR pulse-distance decoder.
`default_nettype none

package nec_ir_pkg;

  localparam int unsigned EdgeCntW      = 6;
  localparam int unsigned FrameEdgesDef = 34;
  localparam int unsigned FrameBitsW    = 32;
  localparam int unsigned BitIdxW       = $clog2(FrameBitsW);
  localparam int unsigned TimeW         = 32;
  localparam int unsigned ThrW          = 16;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned AddrW         = 16;
  localparam int unsigned CmdW          = 8;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned OutDataW      = 32;

  localparam logic OpEdge  = 1'b0;
  localparam logic OpCheck = 1'b1;

  localparam logic [StatusW-1:0] StOk          = 3'd0;
  localparam logic [StatusW-1:0] StLeaderShort = 3'd1;
  localparam logic [StatusW-1:0] StBadBit      = 3'd2;
  localparam logic [StatusW-1:0] StInvFail     = 3'd3;
  localparam logic [StatusW-1:0] StTimeout     = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgGlitchMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLeaderMin = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOneLow    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOneHigh   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgZeroLow   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgZeroHigh  = 3'd6;

  localparam logic [ThrW-1:0]  GlitchMinRst = 16'd700;
  localparam logic [TimeW-1:0] TimeoutRst   = 32'd3000000;
  localparam logic [ThrW-1:0]  LeaderMinRst = 16'd8900;
  localparam logic [ThrW-1:0]  OneLowRst    = 16'd2000;
  localparam logic [ThrW-1:0]  OneHighRst   = 16'd2500;
  localparam logic [ThrW-1:0]  ZeroLowRst   = 16'd1000;
  localparam logic [ThrW-1:0]  ZeroHighRst  = 16'd1250;

  typedef struct packed {
    logic [ThrW-1:0]  glitch_min;
    logic [TimeW-1:0] timeout;
    logic [ThrW-1:0]  leader_min;
    logic [ThrW-1:0]  one_low;
    logic [ThrW-1:0]  one_high;
    logic [ThrW-1:0]  zero_low;
    logic [ThrW-1:0]  zero_high;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [AddrW-1:0]   address;
    logic [StatusW-1:0] status;
  } res_t;

  typedef struct packed {
    logic                emit;
    logic [EdgeCntW-1:0] edge_cnt;
  } core_stat_t;

endpackage

`default_nettype wire

// ----- rtl/nec_ir_cfg.sv -----
// Configuration register bank of the NEC IR decoder.
`default_nettype none

module nec_ir_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nec_ir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nec_ir_pkg::CfgDataW-1:0]  cfg_data_i,
  output nec_ir_pkg::cfg_t                 cfg_o
);
  import nec_ir_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGlitchMin: cfg_d.glitch_min = cfg_data_i[ThrW-1:0];
        CfgTimeout:   cfg_d.timeout    = cfg_data_i[TimeW-1:0];
        CfgLeaderMin: cfg_d.leader_min = cfg_data_i[ThrW-1:0];
        CfgOneLow:    cfg_d.one_low    = cfg_data_i[ThrW-1:0];
        CfgOneHigh:   cfg_d.one_high   = cfg_data_i[ThrW-1:0];
        CfgZeroLow:   cfg_d.zero_low   = cfg_data_i[ThrW-1:0];
        CfgZeroHigh:  cfg_d.zero_high  = cfg_data_i[ThrW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glitch_min <= GlitchMinRst;
      cfg_q.timeout    <= TimeoutRst;
      cfg_q.leader_min <= LeaderMinRst;
      cfg_q.one_low    <= OneLowRst;
      cfg_q.one_high   <= OneHighRst;
      cfg_q.zero_low   <= ZeroLowRst;
      cfg_q.zero_high  <= ZeroHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/nec_ir_core.sv -----
// Frame state and single-step edge classification of the NEC IR decoder.
`default_nettype none

module nec_ir_core #(
  parameter int unsigned FrameEdges = nec_ir_pkg::FrameEdgesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nec_ir_pkg::cfg_t               cfg_i,
  input  logic                           step_i,
  input  logic                           op_i,
  input  logic [nec_ir_pkg::TimeW-1:0]   now_i,
  output nec_ir_pkg::res_t               res_o,
  output nec_ir_pkg::core_stat_t         stat_o
);
  import nec_ir_pkg::*;

  localparam logic [EdgeCntW-1:0] FrameEdgesC = EdgeCntW'(FrameEdges);
  localparam logic [EdgeCntW-1:0] BitsC       = EdgeCntW'(FrameBitsW);
  localparam logic [EdgeCntW-1:0] LeaderCnt   = EdgeCntW'(1);
  localparam logic [EdgeCntW-1:0] BitBase     = EdgeCntW'(2);

  logic [EdgeCntW-1:0]   cnt_q, cnt_d;
  logic [TimeW-1:0]      last_q, last_d;
  logic [FrameBitsW-1:0] bits_q, bits_d;
  logic                  lshort_q, lshort_d;
  logic                  berr_q, berr_d;

  logic [TimeW-1:0]    gap;
  logic                timed_out, glitch, is_one, is_zero, emit;
  logic [EdgeCntW-1:0] cnt_inc, bit_idx;
  logic [CmdW-1:0]     cmd, inv;
  res_t                res;

  assign gap       = now_i - last_q;
  assign timed_out = gap > cfg_i.timeout;
  assign glitch    = gap < {{(TimeW-ThrW){1'b0}}, cfg_i.glitch_min};
  assign is_one    = (gap > {{(TimeW-ThrW){1'b0}}, cfg_i.one_low})
                   && (gap < {{(TimeW-ThrW){1'b0}}, cfg_i.one_high});
  assign is_zero   = (gap > {{(TimeW-ThrW){1'b0}}, cfg_i.zero_low})
                   && (gap < {{(TimeW-ThrW){1'b0}}, cfg_i.zero_high});
  assign cnt_inc   = cnt_q + EdgeCntW'(1);
  assign bit_idx   = cnt_q - BitBase;
  assign cmd       = bits_d[AddrW +: CmdW];
  assign inv       = bits_d[AddrW+CmdW +: CmdW];

  always_comb begin
    cnt_d    = cnt_q;
    last_d   = last_q;
    bits_d   = bits_q;
    lshort_d = lshort_q;
    berr_d   = berr_q;
    emit     = 1'b0;
    res      = '0;
    if (step_i) begin
      if (cnt_q == '0) begin
        if (op_i == OpEdge) begin
          cnt_d    = LeaderCnt;
          last_d   = now_i;
          bits_d   = '0;
          lshort_d = 1'b0;
          berr_d   = 1'b0;
        end
      end else if (timed_out) begin
        cnt_d      = '0;
        emit       = 1'b1;
        res.status = StTimeout;
      end else if (op_i == OpEdge && !glitch) begin
        if (cnt_q == LeaderCnt) begin
          if (gap < {{(TimeW-ThrW){1'b0}}, cfg_i.leader_min}) begin
            lshort_d = 1'b1;
          end
        end else if (is_one) begin
          if (bit_idx < BitsC) begin
            bits_d[bit_idx[BitIdxW-1:0]] = 1'b1;
          end
        end else if (!is_zero) begin
          berr_d = 1'b1;
        end
        cnt_d  = cnt_inc;
        last_d = now_i;
        if (cnt_inc >= FrameEdgesC) begin
          cnt_d = '0;
          emit  = 1'b1;
          priority if (lshort_d) begin
            res.status = StLeaderShort;
          end else if (berr_d) begin
            res.status = StBadBit;
          end else if ((cmd ^ inv) != {CmdW{1'b1}}) begin
            res.status = StInvFail;
          end else begin
            res.status  = StOk;
            res.address = bits_d[AddrW-1:0];
            res.command = cmd;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      last_q   <= '0;
      bits_q   <= '0;
      lshort_q <= 1'b0;
      berr_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      bits_q   <= bits_d;
      lshort_q <= lshort_d;
      berr_q   <= berr_d;
    end
  end

  assign res_o           = res;
  assign stat_o.emit     = emit;
  assign stat_o.edge_cnt = cnt_q;

endmodule

`default_nettype wire

// ----- rtl/nec_ir_pulse_distance_decoder_top.sv -----
// Top level of the NEC IR pulse-distance decoder: stream registers, config, core.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: now_us; tuser: operation
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: status, address, command
//  cfg      | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output does not stall.
// Input register feeds a single-step core; the result sits in an output register.
// A stalled output holds both registers; s_axis_tready stays high while the
// input register is empty or can move on.
// Reset clears the frame state and restores the register defaults.
`default_nettype none
`include "nec_ir_pulse_distance_decoder_top_defines.svh"

module nec_ir_pulse_distance_decoder_top #(
  parameter int unsigned FrameEdges = nec_ir_pkg::FrameEdgesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [nec_ir_pkg::TimeW-1:0]     s_axis_tdata,   // [31:0] now_us
  input  logic                             s_axis_tuser,   // [0] operation
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [nec_ir_pkg::OutDataW-1:0]  m_axis_tdata,   // [2:0] status, [18:3] address,
                                                           // [26:19] command, [31:27] zero
  input  logic                             cfg_we_i,
  input  logic [nec_ir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nec_ir_pkg::CfgDataW-1:0]  cfg_data_i
);
  import nec_ir_pkg::*;

  localparam logic [EdgeCntW-1:0] FrameEdgesC = EdgeCntW'(FrameEdges);

  cfg_t       cfg;
  res_t       core_res;
  core_stat_t core_stat;

  logic             in_vld_q;
  logic             in_op_q;
  logic [TimeW-1:0] in_now_q;
  logic             out_vld_q;
  res_t             out_res_q;
  logic             advance, step;

  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  nec_ir_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  nec_ir_core #(
    .FrameEdges (FrameEdges)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .op_i   (in_op_q),
    .now_i  (in_now_q),
    .res_o  (core_res),
    .stat_o (core_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= step && core_stat.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= s_axis_tuser;
      in_now_q <= s_axis_tdata;
    end
    if (step && core_stat.emit) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(res_t)){1'b0}}, out_res_q};

  `NEC_ASSERT_IMP(a_err_fields_zero,
                  m_axis_tvalid && out_res_q.status != StOk,
                  out_res_q.address == '0 && out_res_q.command == '0,
                  "result fields set on error status")
  `NEC_ASSERT_IMP(a_cnt_range, 1'b1, core_stat.edge_cnt < FrameEdgesC,
                  "edge count reached frame length")
  `NEC_ASSERT_NXT(a_emit_loads, step && core_stat.emit,
                  m_axis_tvalid && out_res_q == $past(core_res),
                  "result not loaded into output register")
  `NEC_ASSERT_NXT(a_emit_idles, step && core_stat.emit, core_stat.edge_cnt == '0,
                  "frame state not idle after result")

endmodule

`default_nettype wire

// ----- dv/nec_ir_frame_checker.sv -----
// Checker for the NEC IR decoder: predicts results of every transfer and compares them.
module nec_ir_frame_checker #(
  parameter int unsigned FrameEdges = nec_ir_pkg::FrameEdgesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [nec_ir_pkg::TimeW-1:0]    s_axis_tdata,   // [31:0] now_us
  input  logic                            s_axis_tuser,   // [0] operation
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [nec_ir_pkg::OutDataW-1:0] m_axis_tdata,   // [2:0] status, [18:3] address,
                                                          // [26:19] command, [31:27] zero
  input  logic                            cfg_we_i,
  input  logic [nec_ir_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nec_ir_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                     fail_cnt_o,
  output int unsigned                     pending_o,
  output int unsigned                     res_cnt_o,
  output int unsigned                     ok_cnt_o
);
  import nec_ir_pkg::*;

  localparam int unsigned ResW = $bits(res_t);

  cfg_t                  dec_cfg;
  logic [EdgeCntW-1:0]   edge_cnt;
  logic [TimeW-1:0]      last_edge_t;
  logic [FrameBitsW-1:0] frame_bits;
  logic                  leader_short;
  logic                  bit_err;
  res_t                  decoded_q[$];
  int unsigned           n_fail;
  int unsigned           n_res;
  int unsigned           n_ok;

  function automatic bit decode_event(input logic op, input logic [TimeW-1:0] now,
                                      output res_t res);
    logic [TimeW-1:0]    gap;
    logic                is_one;
    logic                is_zero;
    logic [CmdW-1:0]     cmd;
    logic [CmdW-1:0]     inv;
    logic [EdgeCntW-1:0] bit_idx;
    res = '0;
    if (edge_cnt == '0) begin
      if (op == OpEdge) begin
        edge_cnt     = EdgeCntW'(1);
        last_edge_t  = now;
        frame_bits   = '0;
        leader_short = 1'b0;
        bit_err      = 1'b0;
      end
      return 1'b0;
    end
    gap = now - last_edge_t;
    if (gap > dec_cfg.timeout) begin
      edge_cnt   = '0;
      res.status = StTimeout;
      return 1'b1;
    end
    if (op != OpEdge || gap < dec_cfg.glitch_min) begin
      return 1'b0;
    end
    if (edge_cnt == 1) begin
      if (gap < dec_cfg.leader_min) leader_short = 1'b1;
    end else begin
      bit_idx = edge_cnt - EdgeCntW'(2);
      is_one  = (gap > dec_cfg.one_low) && (gap < dec_cfg.one_high);
      is_zero = (gap > dec_cfg.zero_low) && (gap < dec_cfg.zero_high);
      if (is_one) begin
        if (bit_idx < EdgeCntW'(FrameBitsW)) frame_bits[bit_idx[BitIdxW-1:0]] = 1'b1;
      end else if (!is_zero) begin
        bit_err = 1'b1;
      end
    end
    edge_cnt    = edge_cnt + 1'b1;
    last_edge_t = now;
    if (edge_cnt < FrameEdges) begin
      return 1'b0;
    end
    cmd      = frame_bits[AddrW +: CmdW];
    inv      = frame_bits[AddrW+CmdW +: CmdW];
    edge_cnt = '0;
    if (leader_short) begin
      res.status = StLeaderShort;
    end else if (bit_err) begin
      res.status = StBadBit;
    end else if ((cmd ^ inv) != {CmdW{1'b1}}) begin
      res.status = StInvFail;
    end else begin
      res.status  = StOk;
      res.address = frame_bits[AddrW-1:0];
      res.command = cmd;
    end
    return 1'b1;
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    n_fail++;
    if (n_fail <= 10) begin
      $display("mismatch: %s at result %0d, expected 0x%0h, got 0x%0h",
               what, n_res, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    res_t want;
    res_t got;
    res_t pred;
    if (!rst_ni) begin
      dec_cfg = '{glitch_min: GlitchMinRst, timeout: TimeoutRst, leader_min: LeaderMinRst,
                  one_low: OneLowRst, one_high: OneHighRst, zero_low: ZeroLowRst,
                  zero_high: ZeroHighRst};
      edge_cnt     = '0;
      last_edge_t  = '0;
      frame_bits   = '0;
      leader_short = 1'b0;
      bit_err      = 1'b0;
      decoded_q.delete();
      n_fail = 0;
      n_res  = 0;
      n_ok   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[ResW-1:0]);
        if (decoded_q.size() == 0) begin
          flag("result with none expected", '0, m_axis_tdata);
        end else begin
          want = decoded_q.pop_front();
          if (got.status !== want.status) begin
            flag("status", 32'(want.status), 32'(got.status));
          end
          if (got.address !== want.address) begin
            flag("address", 32'(want.address), 32'(got.address));
          end
          if (got.command !== want.command) begin
            flag("command", 32'(want.command), 32'(got.command));
          end
          if (m_axis_tdata[OutDataW-1:ResW] !== '0) begin
            flag("padding", '0, 32'(m_axis_tdata[OutDataW-1:ResW]));
          end
          if (want.status == StOk) n_ok++;
        end
        n_res++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_event(s_axis_tuser, s_axis_tdata, pred)) decoded_q.push_back(pred);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGlitchMin: dec_cfg.glitch_min = cfg_data_i[ThrW-1:0];
          CfgTimeout:   dec_cfg.timeout    = cfg_data_i[TimeW-1:0];
          CfgLeaderMin: dec_cfg.leader_min = cfg_data_i[ThrW-1:0];
          CfgOneLow:    dec_cfg.one_low    = cfg_data_i[ThrW-1:0];
          CfgOneHigh:   dec_cfg.one_high   = cfg_data_i[ThrW-1:0];
          CfgZeroLow:   dec_cfg.zero_low   = cfg_data_i[ThrW-1:0];
          CfgZeroHigh:  dec_cfg.zero_high  = cfg_data_i[ThrW-1:0];
          default: begin
          end
        endcase
      end
    end
    fail_cnt_o <= n_fail;
    pending_o  <= decoded_q.size();
    res_cnt_o  <= n_res;
    ok_cnt_o   <= n_ok;
  end

endmodule

// ----- dv/nec_ir_pulse_distance_decoder_top_test.sv -----
// Testbench top: drives edge and time-check events and register writes into the NEC IR decoder, gives verdict.
module nec_ir_pulse_distance_decoder_top_test;
  import nec_ir_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned SettleCycles = 8;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TimeW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tuser  = OpEdge;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = CfgGlitchMin;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned res_cnt;
  int unsigned ok_cnt;

  longint c_gl = GlitchMinRst;
  longint c_to = TimeoutRst;
  longint c_ld = LeaderMinRst;
  longint c_ol = OneLowRst;
  longint c_oh = OneHighRst;
  longint c_zl = ZeroLowRst;
  longint c_zh = ZeroHighRst;

  logic [TimeW-1:0] t_last       = '0;
  int unsigned      items_sent   = 0;
  int unsigned      n_cfg        = 0;
  int unsigned      stall_cycles = 0;
  int unsigned      hold_reqs    = 0;
  int unsigned      hold_done    = 0;
  int unsigned      hold_left    = 0;
  bit               tx_idle_en   = 1'b1;
  bit               rx_idle_en   = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  nec_ir_pulse_distance_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  nec_ir_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .res_cnt_o     (res_cnt),
    .ok_cnt_o      (ok_cnt)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_done != hold_reqs) begin
        hold_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !rx_idle_en || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic longint lmax(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // Random gap in [lo, hi], hi held at the timeout so the frame survives.
  function automatic longint pick(input longint lo, input longint hi);
    if (hi > c_to) hi = c_to;
    if (lo < 0) lo = 0;
    if (lo >= hi) return lo;
    return lo + longint'($urandom_range(hi - lo, 0));
  endfunction

  task automatic send(input logic op, input logic [TimeW-1:0] t);
    int unsigned n;
    n = 0;
    if (tx_idle_en) begin
      while ($urandom_range(99) < 33 && n < 20) n++;
    end
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic wr_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_cfg(input longint gl, input longint to, input longint ld,
                          input longint ol, input longint oh, input longint zl,
                          input longint zh);
    wr_reg(CfgGlitchMin, {16'($urandom), 16'(gl)});
    wr_reg(CfgTimeout, 32'(to));
    wr_reg(CfgLeaderMin, {16'($urandom), 16'(ld)});
    wr_reg(CfgOneLow, {16'($urandom), 16'(ol)});
    wr_reg(CfgOneHigh, {16'($urandom), 16'(oh)});
    wr_reg(CfgZeroLow, {16'($urandom), 16'(zl)});
    wr_reg(CfgZeroHigh, {16'($urandom), 16'(zh)});
    cfg_we_i <= 1'b0;
    c_gl = gl & 64'hFFFF;
    c_to = to & 64'hFFFF_FFFF;
    c_ld = ld & 64'hFFFF;
    c_ol = ol & 64'hFFFF;
    c_oh = oh & 64'hFFFF;
    c_zl = zl & 64'hFFFF;
    c_zh = zh & 64'hFFFF;
    n_cfg++;
  endtask

  task automatic rand_cfg();
    longint gl;
    longint to;
    longint ld;
    longint ol;
    longint oh;
    longint zl;
    longint zh;
    gl = $urandom_range(900);
    ld = $urandom_range(12000);
    zl = $urandom_range(1500);
    zh = zl + $urandom_range(800);
    ol = $urandom_range(4000);
    oh = ol + $urandom_range(1200);
    to = ($urandom_range(3) == 0) ? $urandom_range(6000, 2000) : $urandom_range(4000000, 20000);
    load_cfg(gl, to, ld, ol, oh, zl, zh);
  endtask

  // Send the edge that closes a gap, with an occasional glitch or time check ahead of it.
  task automatic edge_after(input longint g, input bit noisy);
    if (noisy && c_gl > 0 && $urandom_range(24) == 0) begin
      send(OpEdge, t_last + TimeW'($urandom_range(c_gl - 1, 0)));
    end
    if (noisy && $urandom_range(24) == 0) begin
      send(OpCheck, t_last + TimeW'(pick(0, g)));
    end
    send(OpEdge, t_last + TimeW'(g));
    t_last = t_last + TimeW'(g);
  endtask

  task automatic send_frame();
    logic [AddrW-1:0]      addr;
    logic [CmdW-1:0]       cmd;
    logic [CmdW-1:0]       inv;
    logic [FrameBitsW-1:0] word;
    bit                    noisy;
    int unsigned           cut;
    longint                g;
    longint                base;
    longint                extra;
    addr  = $urandom;
    cmd   = $urandom;
    inv   = ($urandom_range(7) == 0) ? CmdW'($urandom) : ~cmd;
    word  = {inv, cmd, addr};
    noisy = ($urandom_range(3) == 0);
    cut   = ($urandom_range(19) == 0) ? $urandom_range(FrameBitsW - 1, 0) : FrameBitsW;
    if ($urandom_range(1)) t_last = $urandom;
    else t_last = t_last + TimeW'($urandom_range(100000));
    send(OpEdge, t_last);
    base = lmax(c_gl, c_ld);
    if ($urandom_range(9) == 0 && c_ld > c_gl) g = pick(c_gl, c_ld - 1);
    else g = pick(base, base + 4000);
    edge_after(g, noisy);
    for (int i = 0; i < FrameBitsW; i++) begin
      if (i == cut) begin
        if (c_to < 64'hFFFF_FFFF) begin
          extra = $urandom_range(5000);
          if (c_to + 1 + extra > 64'hFFFF_FFFF) extra = 0;
          send(logic'($urandom_range(1)), t_last + TimeW'(c_to + 1 + extra));
        end
        return;
      end
      if (noisy && $urandom_range(29) == 0) g = pick(c_gl, c_gl + 3000);
      else if (word[i]) g = pick(lmax(c_ol + 1, c_gl), c_oh - 1);
      else g = pick(lmax(c_zl + 1, c_gl), c_zh - 1);
      edge_after(g, noisy);
    end
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned noise_pct);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < noise_pct) send(logic'($urandom_range(1)), $urandom);
      else send_frame();
    end
  endtask

  initial begin
    logic [TimeW-1:0] tt;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OpCheck, 32'h0);
    tt = 32'hFFFF_FFFF;
    send(OpEdge, tt);
    send(OpEdge, tt + 32'd699);
    tt = tt + 32'd700;
    send(OpEdge, tt);
    send(OpCheck, tt + TimeoutRst);
    send(OpCheck, tt + TimeoutRst + 32'd1);
    send(OpCheck, 32'd5);
    tt = '0;
    send(OpEdge, tt);
    tt += 32'(LeaderMinRst);
    send(OpEdge, tt);
    tt += 32'd2250;
    send(OpEdge, tt);
    tt += 32'd1125;
    send(OpEdge, tt);
    tt += 32'(OneLowRst);
    send(OpEdge, tt);
    tt += 32'(ZeroHighRst);
    send(OpEdge, tt);
    send(OpEdge, tt + TimeoutRst + 32'd1);
    tt = 32'h1234_5678;
    send(OpEdge, tt);

    drain();
    load_cfg(64'hFFFF, 64'h0, 64'hFFFF, 64'hFFFF, 64'h0, 64'hFFFF, 64'h0);
    send(OpEdge, tt);
    send(OpCheck, tt + 32'd1);
    send(OpEdge, 32'h0);
    send(OpEdge, 32'h1);

    drain();
    load_cfg(64'h0, 64'hFFFF_FFFF, 64'h0, 64'h0, 64'hFFFF, 64'h0, 64'hFFFF);
    tt = 32'h8000_0000;
    send(OpEdge, tt);
    send(OpEdge, tt);
    send(OpEdge, tt);
    tt += 32'd65535;
    send(OpEdge, tt);
    tt += 32'd65534;
    send(OpEdge, tt);
    tt += 32'hFFFF_FFFF;
    send(OpEdge, tt);
    t_last = tt;

    drain();
    load_cfg(GlitchMinRst, TimeoutRst, LeaderMinRst, OneLowRst, OneHighRst, ZeroLowRst,
             ZeroHighRst);
    run_phase(150, 8);
    hold_reqs++;
    run_phase(150, 8);

    drain();
    load_cfg(64'h0, 64'hFFFF_FFFF, 64'h0, 64'h0, 64'hFFFF, 64'h0, 64'hFFFF);
    run_phase(200, 5);

    drain();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rand_cfg();
    run_phase(250, 8);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (3) begin
      drain();
      rand_cfg();
      run_phase(250, 10);
    end
    drain();

    $display("covered %0d stream items under %0d register settings: edge cases, then frames",
             items_sent, n_cfg);
    $display("checked %0d results, %0d decoded frames, %0d mismatches",
             res_cnt, ok_cnt, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
